>>> sv/ddpm_pkg.sv
// Shared constants and types for the differential drive PWM mixer.
package ddpm_pkg;

  localparam int unsigned CmdW    = 8;
  localparam int unsigned WheelW  = 10;
  localparam int unsigned MagW    = 9;
  localparam int unsigned NumW    = 15;
  localparam int unsigned QuotW   = 7;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned ProdW   = 23;
  localparam int unsigned RecipW  = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [QuotW-1:0]  FullScale  = 7'd100;
  localparam logic [RecipW-1:0] RecipK     = 24'd10737419;
  localparam int unsigned       RecipShift = 30;

  localparam logic [DutyW-1:0] PeriodReset = 16'd7200;
  localparam logic [DutyW-1:0] FloorReset  = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeriod = 2'd0,
    RegFloor  = 2'd1
  } ddpm_reg_e;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } ddpm_adv_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] num;
  } ddpm_wheel_t;

endpackage

>>> sv/ddpm_wheel.sv
// Per-wheel datapath: two-stage divider, span multiply, reciprocal divide by 100 and duty select.
module ddpm_wheel (
  input  logic                      clk_i,
  input  ddpm_pkg::ddpm_adv_t       adv_i,
  input  ddpm_pkg::ddpm_wheel_t     wheel_i,
  input  logic [ddpm_pkg::MagW-1:0] div_i,
  input  logic [ddpm_pkg::DutyW-1:0] span_mag_i,
  input  logic                      span_neg_i,
  input  logic [ddpm_pkg::DutyW-1:0] floor_i,
  output logic [ddpm_pkg::DutyW-1:0] fwd_o,
  output logic [ddpm_pkg::DutyW-1:0] rev_o
);
  import ddpm_pkg::*;

  logic [NumW-1:0]   rem2_d, rem2_q;
  logic [3:0]        quo2_d, quo2_q;
  logic [MagW-1:0]   div2_q;
  logic              neg2_q;
  logic [QuotW-1:0]  mag3_d, mag3_q;
  logic              neg3_q;
  logic [ProdW-1:0]  prod4_q;
  logic              nz4_q, neg4_q;
  logic [DutyW-1:0]  quo5_q;
  logic              nz5_q, neg5_q;
  logic [ProdW+RecipW-1:0] recip_prod;
  logic [DutyW-1:0]  duty;
  logic [DutyW-1:0]  fwd_q, rev_q;

  always_comb begin
    logic [NumW-1:0] rem;
    logic [NumW-1:0] trial;
    rem    = wheel_i.num;
    quo2_d = '0;
    for (int i = 0; i < 4; i++) begin
      trial = NumW'(div_i) << (6 - i);
      if (rem >= trial) begin
        rem           = rem - trial;
        quo2_d[3 - i] = 1'b1;
      end
    end
    rem2_d = rem;
  end

  always_comb begin
    logic [NumW-1:0] rem;
    logic [NumW-1:0] trial;
    logic [2:0]      lo;
    rem = rem2_q;
    lo  = '0;
    for (int i = 0; i < 3; i++) begin
      trial = NumW'(div2_q) << (2 - i);
      if (rem >= trial) begin
        rem        = rem - trial;
        lo[2 - i]  = 1'b1;
      end
    end
    mag3_d = {quo2_q, lo};
  end

  assign recip_prod = (ProdW + RecipW)'(prod4_q) * (ProdW + RecipW)'(RecipK);

  assign duty = span_neg_i ? (floor_i - quo5_q) : (floor_i + quo5_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      rem2_q <= rem2_d;
      quo2_q <= quo2_d;
      div2_q <= div_i;
      neg2_q <= wheel_i.neg;
    end
    if (adv_i.s3) begin
      mag3_q <= mag3_d;
      neg3_q <= neg2_q;
    end
    if (adv_i.s4) begin
      prod4_q <= ProdW'(mag3_q) * ProdW'(span_mag_i);
      nz4_q   <= (mag3_q != '0);
      neg4_q  <= neg3_q;
    end
    if (adv_i.s5) begin
      quo5_q <= recip_prod[RecipShift +: DutyW];
      nz5_q  <= nz4_q;
      neg5_q <= neg4_q;
    end
    if (adv_i.s6) begin
      fwd_q <= (nz5_q && !neg5_q) ? duty : '0;
      rev_q <= (nz5_q && neg5_q) ? duty : '0;
    end
  end

  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

>>> sv/differential_drive_pwm_mixer.sv
// Top level of the differential drive PWM mixer with config registers and pipeline control.
// Throughput: one beat per cycle while the output is not stalled, set by six
// register stages (mix, two divider stages, span multiply, reciprocal multiply,
// duty select), each with its own valid bit.
// A stalled output holds the last stage; earlier stages keep filling until all six hold a beat.
// Reset clears all valid bits and sets the period to 7200 and the duty floor to 0.
module differential_drive_pwm_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // speed, yaw_rate
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // left_forward_duty, left_reverse_duty,
                                                        // right_forward_duty, right_reverse_duty
  input  logic                          cfg_we_i,
  input  logic [ddpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddpm_pkg::DutyW-1:0]    cfg_wdata_i
);
  import ddpm_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [DutyW-1:0] period_q, floor_q;
  logic [DutyW-1:0] span_mag;
  logic             span_neg;

  logic [NumStages-1:0] v_d, v_q, rdy;
  ddpm_adv_t            adv;
  logic                 load1;

  logic [CmdW-1:0]          speed, yaw;
  logic signed [WheelW-1:0] left_w, right_w;
  logic [MagW-1:0]          left_mag, right_mag, mx, div1_d, div1_q;
  logic                     scale;
  ddpm_wheel_t              left1_d, left1_q, right1_d, right1_q;

  logic [DutyW-1:0] lf_duty, lr_duty, rf_duty, rr_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      floor_q  <= FloorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPeriod: period_q <= cfg_wdata_i;
        RegFloor:  floor_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign span_neg = (floor_q > period_q);
  assign span_mag = span_neg ? (floor_q - period_q) : (period_q - floor_q);

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
    v_d[0] = rdy[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = rdy[k] ? v_q[k - 1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign load1  = rdy[0] && s_axis_tvalid;
  assign adv.s2 = rdy[1] && v_q[0];
  assign adv.s3 = rdy[2] && v_q[1];
  assign adv.s4 = rdy[3] && v_q[2];
  assign adv.s5 = rdy[4] && v_q[3];
  assign adv.s6 = rdy[5] && v_q[4];

  assign s_axis_tready = rdy[0];

  assign speed = s_axis_tdata[7:0];
  assign yaw   = s_axis_tdata[15:8];

  always_comb begin
    left_w    = $signed({{2{speed[7]}}, speed}) - $signed({{2{yaw[7]}}, yaw});
    right_w   = $signed({{2{speed[7]}}, speed}) + $signed({{2{yaw[7]}}, yaw});
    left_mag  = left_w[WheelW-1]  ? MagW'(-left_w)  : left_w[MagW-1:0];
    right_mag = right_w[WheelW-1] ? MagW'(-right_w) : right_w[MagW-1:0];
    mx        = (left_mag > right_mag) ? left_mag : right_mag;
    scale     = (mx > MagW'(FullScale));
    // Without rescaling, dividing by full scale returns the magnitude itself.
    div1_d        = scale ? mx : MagW'(FullScale);
    left1_d.neg   = left_w[WheelW-1];
    left1_d.num   = NumW'(left_mag) * NumW'(FullScale);
    right1_d.neg  = right_w[WheelW-1];
    right1_d.num  = NumW'(right_mag) * NumW'(FullScale);
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      left1_q  <= left1_d;
      right1_q <= right1_d;
      div1_q   <= div1_d;
    end
  end

  ddpm_wheel u_left (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .wheel_i    (left1_q),
    .div_i      (div1_q),
    .span_mag_i (span_mag),
    .span_neg_i (span_neg),
    .floor_i    (floor_q),
    .fwd_o      (lf_duty),
    .rev_o      (lr_duty)
  );

  ddpm_wheel u_right (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .wheel_i    (right1_q),
    .div_i      (div1_q),
    .span_mag_i (span_mag),
    .span_neg_i (span_neg),
    .floor_i    (floor_q),
    .fwd_o      (rf_duty),
    .rev_o      (rr_duty)
  );

  assign m_axis_tvalid = v_q[NumStages-1];
  assign m_axis_tdata  = {rr_duty, rf_duty, lr_duty, lf_duty};

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> s_axis_tready)
    else $error("input not ready while first stage is empty");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (left1_q.num < {div1_q, 7'b0}) && (right1_q.num < {div1_q, 7'b0}) &&
               (div1_q >= MagW'(FullScale)))
    else $error("divider operands out of range");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((lf_duty != '0) && (lr_duty != '0)) &&
                      !((rf_duty != '0) && (rr_duty != '0)))
    else $error("both directions of one wheel driven");

endmodule

>>> bench/mixer_checker.sv
// Watches the command, result and register ports of the PWM mixer and checks every result beat.
module mixer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [15:0]                   s_data_i,
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [63:0]                   m_data_i,
  input  logic                          cfg_we_i,
  input  logic [ddpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddpm_pkg::DutyW-1:0]    cfg_wdata_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o
);
  import ddpm_pkg::*;

  localparam int          Scale     = int'(FullScale);
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [DutyW-1:0] right_rev;
    logic [DutyW-1:0] right_fwd;
    logic [DutyW-1:0] left_rev;
    logic [DutyW-1:0] left_fwd;
  } duty_set_t;

  logic [DutyW-1:0] period_q;
  logic [DutyW-1:0] floor_q;
  duty_set_t        duty_q [$];

  function automatic logic [DutyW-1:0] wheel_duty(input int mag);
    longint span;
    longint duty;
    if (mag == 0) begin
      return '0;
    end
    span = longint'(period_q) - longint'(floor_q);
    duty = longint'(floor_q) + (longint'(mag) * span) / Scale;
    return duty[DutyW-1:0];
  endfunction

  function automatic duty_set_t mix_duties(input logic signed [CmdW-1:0] speed,
                                           input logic signed [CmdW-1:0] yaw);
    int        left;
    int        right;
    int        peak;
    duty_set_t duties;
    left  = int'(speed) - int'(yaw);
    right = int'(speed) + int'(yaw);
    peak  = (left < 0) ? -left : left;
    if (((right < 0) ? -right : right) > peak) begin
      peak = (right < 0) ? -right : right;
    end
    if (peak > Scale) begin
      left  = (left * Scale) / peak;
      right = (right * Scale) / peak;
    end
    duties.left_fwd  = (left > 0)  ? wheel_duty(left)   : '0;
    duties.left_rev  = (left < 0)  ? wheel_duty(-left)  : '0;
    duties.right_fwd = (right > 0) ? wheel_duty(right)  : '0;
    duties.right_rev = (right < 0) ? wheel_duty(-right) : '0;
    return duties;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t want;
    duty_set_t got;
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      floor_q    <= FloorReset;
      err_cnt_o  = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPeriod: begin
            period_q <= cfg_wdata_i;
          end
          RegFloor: begin
            floor_q <= cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        duty_q.push_back(mix_duties(s_data_i[7:0], s_data_i[15:8]));
      end
      if (m_valid_i && m_ready_i) begin
        got = duty_set_t'(m_data_i);
        if (duty_q.size() == 0) begin
          if (err_cnt_o < ReportMax) begin
            $display("mixer_checker: result beat with nothing pending:");
            $display("mixer_checker:   actual lf=%0d lr=%0d rf=%0d rr=%0d",
                     got.left_fwd, got.left_rev, got.right_fwd, got.right_rev);
          end
          err_cnt_o = err_cnt_o + 1;
        end else begin
          want = duty_q.pop_front();
          if (got !== want) begin
            if (err_cnt_o < ReportMax) begin
              $display("mixer_checker: expected lf=%0d lr=%0d rf=%0d rr=%0d",
                       want.left_fwd, want.left_rev, want.right_fwd, want.right_rev);
              $display("mixer_checker:   actual lf=%0d lr=%0d rf=%0d rr=%0d",
                       got.left_fwd, got.left_rev, got.right_fwd, got.right_rev);
            end
            err_cnt_o = err_cnt_o + 1;
          end
        end
      end
      pending_o = duty_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// Top of the PWM mixer testbench: clock, reset, command and register stimulus, and the verdict.
module tb_top;
  import ddpm_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainGap   = 8;
  localparam int unsigned EndWait    = 20;
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned NumSets    = 4;
  localparam int unsigned SetItems   = 80;
  localparam int unsigned NumDirect  = 20;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [15:0]         s_data    = '0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [63:0]         m_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [DutyW-1:0]    cfg_wdata = '0;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned snd_idle    = 0;
  int unsigned rcv_idle    = 0;
  int unsigned idle_cycles = 0;
  bit          hold_go     = 1'b0;

  int direct_cmds [NumDirect][2] = '{
    '{0, 0}, '{127, 127}, '{-128, -128}, '{127, -128}, '{-128, 127},
    '{100, 0}, '{-100, 0}, '{0, 100}, '{0, -100}, '{101, 0},
    '{1, 0}, '{-1, 0}, '{50, 50}, '{50, -50}, '{-128, 0},
    '{0, 127}, '{120, -10}, '{-7, -120}, '{1, -1}, '{3, 97}
  };

  logic [DutyW-1:0] period_set [12] = '{
    16'd65535, 16'd0, 16'd1, 16'd65535, 16'd100, 16'd0,
    16'd40000, 16'd1000, 16'd7200, 16'd0, 16'd0, 16'd255
  };
  logic [DutyW-1:0] min_set [12] = '{
    16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535,
    16'd1000, 16'd40000, 16'd720, 16'd0, 16'd0, 16'd3
  };

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  differential_drive_pwm_mixer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),     // speed, yaw_rate
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),     // left_forward_duty, left_reverse_duty,
                                 // right_forward_duty, right_reverse_duty
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  mixer_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  task automatic send_cmd(input logic [CmdW-1:0] speed, input logic [CmdW-1:0] yaw);
    while ($urandom_range(99) < snd_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {yaw, speed};
    @(posedge clk);
    while (!s_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [CmdW-1:0] speed;
    logic [CmdW-1:0] yaw;
    int unsigned     pick;
    pick  = $urandom_range(9);
    speed = CmdW'($urandom);
    yaw   = CmdW'($urandom);
    if (pick < 3) begin
      speed = 8'($urandom_range(120)) - 8'd60;
      yaw   = 8'($urandom_range(120)) - 8'd60;
    end else if (pick == 3) begin
      yaw = speed;
    end else if (pick == 4) begin
      yaw = -speed;
    end
    send_cmd(speed, yaw);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DutyW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      if (hold_go) begin
        m_ready <= 1'b0;
        hold_go = 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        m_ready <= ($urandom_range(99) >= rcv_idle);
      end
      @(posedge clk);
    end
  end

  initial begin
    int unsigned set_no;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle = 12;
    rcv_idle = 76;
    for (int i = 0; i < NumDirect; i++) begin
      send_cmd(8'(direct_cmds[i][0]), 8'(direct_cmds[i][1]));
    end
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 12 : (ph == 1) ? 76 : 0;
      rcv_idle = (ph == 0) ? 76 : (ph == 1) ? 12 : 0;
      for (int c = 0; c < NumSets; c++) begin
        drain();
        set_no = ph * NumSets + c;
        if (set_no == 9 || set_no == 10) begin
          period_set[set_no] = DutyW'($urandom);
          min_set[set_no]    = DutyW'($urandom);
        end
        cfg_write(RegPeriod, period_set[set_no]);
        cfg_write(RegFloor, min_set[set_no]);
        if (c == 2) begin
          cfg_write(RegSpareLo, DutyW'($urandom));
          cfg_write(RegSpareHi, DutyW'($urandom));
        end
        if (ph == 0 && c == 1) begin
          hold_go = 1'b1;
        end
        for (int n = 0; n < SetItems; n++) begin
          send_random();
        end
      end
    end
    drain();
    repeat (EndWait) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
